// ===== hdl/encoder_rpm_slew_odometer_defines.svh =====
// ----------------------------------------------------------------------------
// Encoder rpm slew odometer assertion macros
// Shared concurrent property forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ENCODER_RPM_SLEW_ODOMETER_DEFINES_SVH
`define ENCODER_RPM_SLEW_ODOMETER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ERSO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ERSO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/erso_pkg.sv =====
// ----------------------------------------------------------------------------
// Encoder rpm slew odometer package
// Field widths, register map codes, reset values and default constants.
// ----------------------------------------------------------------------------
package erso_pkg;

	localparam int CNT_W    = 16;
	localparam int POS_W    = 10;
	localparam int RPC_W    = 10;
	localparam int RPM_W    = 16;
	localparam int SPEED_W  = 10;
	localparam int PERIOD_W = 8;
	localparam int DIST_W   = 16;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam int SPEED_DIVISOR_DEF      = 33;
	localparam int UNITS_PER_TENTH_KM_DEF = 36000;

	localparam logic [2:0] REG_RPM_PER_COUNT = 3'd0;
	localparam logic [2:0] REG_MAX_POSITION  = 3'd1;
	localparam logic [2:0] REG_SLEW_STEP     = 3'd2;
	localparam logic [2:0] REG_SPEED_MAX     = 3'd3;
	localparam logic [2:0] REG_REPORT_PERIOD = 3'd4;

	localparam logic [RPC_W-1:0]    RST_RPM_PER_COUNT = 10'd100;
	localparam logic [POS_W-1:0]    RST_MAX_POSITION  = 10'd100;
	localparam logic [RPM_W-1:0]    RST_SLEW_STEP     = 16'd50;
	localparam logic [SPEED_W-1:0]  RST_SPEED_MAX     = 10'd300;
	localparam logic [PERIOD_W-1:0] RST_REPORT_PERIOD = 8'd10;

	typedef struct packed {
		logic [RPC_W-1:0]    rpm_per_count;
		logic [POS_W-1:0]    max_position;
		logic [RPM_W-1:0]    slew_step;
		logic [SPEED_W-1:0]  speed_max;
		logic [PERIOD_W-1:0] report_period;
	} cfg_t;

endpackage

// ===== hdl/encoder_rpm_slew_odometer.sv =====
// ----------------------------------------------------------------------------
// Encoder rpm slew odometer
// Turns quadrature counter ticks into slew-limited rpm, speed and trip distance.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the input channel (in_valid/in_ready, counter_value) is
//   one tick carrying the free-running 16-bit encoder counter. Each tick
//   yields exactly one result on the output channel (out_valid/out_ready):
//   rpm_out, road_speed, trip_tenths and the trip_due flag.
//   One request is taken every cycle unless the output stalls. The four stages
//   before the result register are: position and target multiply, slew,
//   reciprocal multiply for rpm / SPEED_DIVISOR, then clamp and odometer. Each
//   stage owns the state it updates, so consecutive ticks never wait. When the
//   receiver stalls, each stage holds its request only while the stage after
//   it is full; bubbles still fill, so in_ready drops only once every stage and
//   the result register are occupied. Reset (arst_n low) empties the pipeline,
//   zeroes position, rpm, trip and tick state and loads the register defaults.
//   Configuration goes through the APB port (registers at 0x0..0x10) and is to
//   be written by the user only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "encoder_rpm_slew_odometer_defines.svh"

module encoder_rpm_slew_odometer #(
	parameter int SPEED_DIVISOR      = erso_pkg::SPEED_DIVISOR_DEF,
	parameter int UNITS_PER_TENTH_KM = erso_pkg::UNITS_PER_TENTH_KM_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// APB configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [erso_pkg::ADDR_W-1:0]   paddr,
	input  logic [erso_pkg::DATA_W-1:0]   pwdata,
	output logic [erso_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	// tick input
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [erso_pkg::CNT_W-1:0]    counter_value,
	// result output
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [erso_pkg::RPM_W-1:0]    rpm_out,
	output logic [erso_pkg::SPEED_W-1:0]  road_speed,
	output logic [erso_pkg::DIST_W-1:0]   trip_tenths,
	output logic                          trip_due
);

	import erso_pkg::*;

	// rpm / SPEED_DIVISOR as a multiply by a rounded-up reciprocal; exact for
	// every 16-bit rpm with this shift.
	localparam int DIV_SHIFT = RPM_W + $clog2(SPEED_DIVISOR);
	localparam int PROD_W    = DIV_SHIFT + RPM_W;
	localparam longint unsigned DIV_MULT =
		((64'd1 << DIV_SHIFT) + longint'(SPEED_DIVISOR) - 64'd1) / longint'(SPEED_DIVISOR);
	localparam logic [PROD_W-1:0] DIV_MULT_V = PROD_W'(DIV_MULT);
	localparam logic [DIST_W:0]   UNITS_V    = (DIST_W + 1)'(UNITS_PER_TENTH_KM);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	cfg_t       cfg_q;
	logic       cfg_wr;
	logic [2:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rpm_per_count <= RST_RPM_PER_COUNT;
			cfg_q.max_position  <= RST_MAX_POSITION;
			cfg_q.slew_step     <= RST_SLEW_STEP;
			cfg_q.speed_max     <= RST_SPEED_MAX;
			cfg_q.report_period <= RST_REPORT_PERIOD;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_RPM_PER_COUNT: cfg_q.rpm_per_count <= pwdata[RPC_W-1:0];
				REG_MAX_POSITION:  cfg_q.max_position  <= pwdata[POS_W-1:0];
				REG_SLEW_STEP:     cfg_q.slew_step     <= pwdata[RPM_W-1:0];
				REG_SPEED_MAX:     cfg_q.speed_max     <= pwdata[SPEED_W-1:0];
				REG_REPORT_PERIOD: cfg_q.report_period <= pwdata[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back; unmapped addresses read as zero.
	always_comb begin
		case (cfg_idx)
			REG_RPM_PER_COUNT: prdata = DATA_W'(cfg_q.rpm_per_count);
			REG_MAX_POSITION:  prdata = DATA_W'(cfg_q.max_position);
			REG_SLEW_STEP:     prdata = DATA_W'(cfg_q.slew_step);
			REG_SPEED_MAX:     prdata = DATA_W'(cfg_q.speed_max);
			REG_REPORT_PERIOD: prdata = DATA_W'(cfg_q.report_period);
			default:           prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Pipeline flow control: a stage takes a new request when it is empty
	// or its request is leaving in the same cycle.
	// ------------------------------------------------------------------
	logic valid_s1, valid_s2, valid_s3, valid_s4, out_valid_q;
	logic ready_s2, ready_s3, ready_s4, ready_out;
	logic move_s1, move_s2, move_s3, move_s4;

	assign ready_out = !out_valid_q || out_ready;
	assign ready_s4  = !valid_s4 || ready_out;
	assign ready_s3  = !valid_s3 || ready_s4;
	assign ready_s2  = !valid_s2 || ready_s3;
	assign in_ready  = !valid_s1 || ready_s2;

	assign move_s1 = valid_s1 && ready_s2;
	assign move_s2 = valid_s2 && ready_s3;
	assign move_s3 = valid_s3 && ready_s4;
	assign move_s4 = valid_s4 && ready_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
			if (ready_out) out_valid_q <= valid_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: input register, position update and target rpm
	// ------------------------------------------------------------------
	logic [CNT_W-1:0]   counter_s1;
	logic [CNT_W-1:0]   prev_count_q;
	logic [POS_W-1:0]   position_q;
	logic [RPM_W-1:0]   target_q;
	logic [CNT_W-1:0]   delta;
	logic signed [CNT_W+1:0] pos_sum;
	logic [POS_W-1:0]   pos_next;
	logic [POS_W+RPC_W-1:0] target_prod;
	logic [RPM_W-1:0]   target_next;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			counter_s1 <= counter_value;
		end
	end

	assign delta   = counter_s1 - prev_count_q;
	// Signed wrapped difference added to the unsigned position.
	assign pos_sum = $signed({2'b00, CNT_W'(position_q)}) + $signed({{2{delta[CNT_W-1]}}, delta});

	always_comb begin
		if (pos_sum < 0) begin
			pos_next = '0;
		end else if (pos_sum > $signed({2'b00, CNT_W'(cfg_q.max_position)})) begin
			pos_next = cfg_q.max_position;
		end else begin
			pos_next = pos_sum[POS_W-1:0];
		end
	end

	assign target_prod = pos_next * cfg_q.rpm_per_count;
	assign target_next = (target_prod > (POS_W+RPC_W)'({RPM_W{1'b1}})) ?
		{RPM_W{1'b1}} : target_prod[RPM_W-1:0];

	// Hold position and target while the counter has not moved.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_count_q <= '0;
			position_q   <= '0;
			target_q     <= '0;
		end else if (move_s1 && (delta != '0)) begin
			prev_count_q <= counter_s1;
			position_q   <= pos_next;
			target_q     <= target_next;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: slew present rpm toward the target
	// ------------------------------------------------------------------
	logic [RPM_W-1:0] present_rpm_q;
	logic [RPM_W:0]   rpm_up;
	logic [RPM_W-1:0] rpm_gap;
	logic [RPM_W-1:0] rpm_next;

	assign rpm_up  = {1'b0, present_rpm_q} + {1'b0, cfg_q.slew_step};
	assign rpm_gap = present_rpm_q - target_q;

	always_comb begin
		if (present_rpm_q < target_q) begin
			rpm_next = (rpm_up > {1'b0, target_q}) ? target_q : rpm_up[RPM_W-1:0];
		end else if (present_rpm_q > target_q) begin
			rpm_next = (cfg_q.slew_step >= rpm_gap) ? target_q :
				present_rpm_q - cfg_q.slew_step;
		end else begin
			rpm_next = present_rpm_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_rpm_q <= '0;
		end else if (move_s2) begin
			present_rpm_q <= rpm_next;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: reciprocal multiply; present_rpm_q belongs to the request in
	// this stage until it leaves.
	// ------------------------------------------------------------------
	logic [PROD_W-1:0] speed_prod_s4;
	logic [RPM_W-1:0]  rpm_s4;

	always_ff @(posedge clk) begin
		if (move_s3) begin
			speed_prod_s4 <= PROD_W'(present_rpm_q) * DIV_MULT_V;
			rpm_s4        <= present_rpm_q;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: speed clamp, odometer and report tick
	// ------------------------------------------------------------------
	logic [RPM_W-1:0]    speed_quot;
	logic [SPEED_W-1:0]  speed_next;
	logic [DIST_W-1:0]   remainder_q;
	logic [DIST_W-1:0]   tenths_q;
	logic [PERIOD_W-1:0] tick_q;
	logic [DIST_W:0]     dist_sum;
	logic                dist_carry;
	logic [PERIOD_W-1:0] tick_inc;
	logic                due_next;

	assign speed_quot = speed_prod_s4[DIV_SHIFT +: RPM_W];
	assign speed_next = (speed_quot > RPM_W'(cfg_q.speed_max)) ?
		cfg_q.speed_max : speed_quot[SPEED_W-1:0];

	assign dist_sum   = {1'b0, remainder_q} + (DIST_W + 1)'(speed_next);
	assign dist_carry = (dist_sum >= UNITS_V);

	assign tick_inc = tick_q + PERIOD_W'(1);
	assign due_next = (tick_inc >= cfg_q.report_period);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remainder_q <= '0;
			tenths_q    <= '0;
			tick_q      <= '0;
		end else if (move_s4) begin
			if (dist_carry) begin
				remainder_q <= DIST_W'(dist_sum - UNITS_V);
				tenths_q    <= tenths_q + DIST_W'(1);
			end else begin
				remainder_q <= dist_sum[DIST_W-1:0];
			end
			tick_q <= due_next ? '0 : tick_inc;
		end
	end

	// Result register: carry tenths including this request's carry.
	logic [RPM_W-1:0]   rpm_out_q;
	logic [SPEED_W-1:0] speed_q;
	logic [DIST_W-1:0]  trip_q;
	logic               due_q;

	always_ff @(posedge clk) begin
		if (move_s4) begin
			rpm_out_q <= rpm_s4;
			speed_q   <= speed_next;
			trip_q    <= dist_carry ? tenths_q + DIST_W'(1) : tenths_q;
			due_q     <= due_next;
		end
	end

	assign out_valid   = out_valid_q;
	assign rpm_out     = rpm_out_q;
	assign road_speed  = speed_q;
	assign trip_tenths = trip_q;
	assign trip_due    = due_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`ERSO_ASSERT_NEXT(a_target_hold, clk, arst_n,
		move_s1 && (counter_s1 == prev_count_q),
		$stable(target_q) && $stable(position_q),
		"target or position moved on an unchanged counter")

	`ERSO_ASSERT_NEXT(a_slew_bound, clk, arst_n,
		move_s2,
		((present_rpm_q >= $past(present_rpm_q)) ?
			(present_rpm_q - $past(present_rpm_q)) :
			($past(present_rpm_q) - present_rpm_q)) <= $past(cfg_q.slew_step),
		"present rpm moved by more than the slew step")

	`ERSO_ASSERT_NOW(a_remainder_range, clk, arst_n,
		1'b1,
		(DIST_W + 1)'(remainder_q) < UNITS_V,
		"distance remainder reached a full tenth")

endmodule

// ===== bench/odometer_checker.sv =====
// ----------------------------------------------------------------------------
// Odometer reading checker
// Follows register writes and tick requests, predicts each dashboard reading
// and compares it field by field with what the block hands out.
// ----------------------------------------------------------------------------
module odometer_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic                                pready,
	input  logic [erso_pkg::ADDR_W-1:0]         paddr,
	input  logic [erso_pkg::DATA_W-1:0]         pwdata,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic [erso_pkg::CNT_W-1:0]          counter_value,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic [erso_pkg::RPM_W-1:0]          rpm_out,
	input  logic [erso_pkg::SPEED_W-1:0]        road_speed,
	input  logic [erso_pkg::DIST_W-1:0]         trip_tenths,
	input  logic                                trip_due,
	output int                                  fail_count,
	output int                                  outstanding,
	output int                                  readings_checked,
	output int                                  due_flags,
	output int                                  tenth_carries
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [erso_pkg::RPM_W-1:0]   rpm;
		logic [erso_pkg::SPEED_W-1:0] speed;
		logic [erso_pkg::DIST_W-1:0]  trip;
		logic                         due;
	} reading_t;

	erso_pkg::cfg_t                  cfg;
	logic [erso_pkg::CNT_W-1:0]      last_count;
	logic [erso_pkg::POS_W-1:0]      position;
	logic [erso_pkg::RPM_W-1:0]      goal_rpm;
	logic [erso_pkg::RPM_W-1:0]      present_rpm;
	logic [erso_pkg::DIST_W-1:0]     trip_remainder;
	logic [erso_pkg::DIST_W-1:0]     trip_count;
	logic [erso_pkg::PERIOD_W-1:0]   tick_count;
	reading_t                        readings_in_flight[$];

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		fail_count++;
	endtask

	// Advance the odometer state by one tick and return the reading it gives.
	task automatic step_odometer(input logic [erso_pkg::CNT_W-1:0] now, output reading_t r);
		logic [erso_pkg::CNT_W-1:0] delta;
		int signed   pos_next;
		int unsigned product;
		int unsigned rpm_up;
		int unsigned rpm_gap;
		int unsigned spd;
		int unsigned sum;
		delta = now - last_count;
		// a still encoder holds position and target
		if (delta != '0) begin
			pos_next = int'(position) + int'($signed(delta));
			if (pos_next < 0)
				pos_next = 0;
			if (pos_next > int'(cfg.max_position))
				pos_next = int'(cfg.max_position);
			position = pos_next[erso_pkg::POS_W-1:0];
			product = 32'(position) * 32'(cfg.rpm_per_count);
			goal_rpm = (product > 32'hFFFF) ? 16'hFFFF : product[15:0];
			last_count = now;
		end
		if (present_rpm < goal_rpm) begin
			rpm_up = 32'(present_rpm) + 32'(cfg.slew_step);
			present_rpm = (rpm_up > 32'(goal_rpm)) ? goal_rpm : rpm_up[15:0];
		end else if (present_rpm > goal_rpm) begin
			rpm_gap = 32'(present_rpm - goal_rpm);
			present_rpm = (32'(cfg.slew_step) >= rpm_gap) ? goal_rpm
				: present_rpm - cfg.slew_step;
		end
		spd = 32'(present_rpm) / erso_pkg::SPEED_DIVISOR_DEF;
		if (spd > 32'(cfg.speed_max))
			spd = 32'(cfg.speed_max);
		sum = 32'(trip_remainder) + spd;
		if (sum >= erso_pkg::UNITS_PER_TENTH_KM_DEF) begin
			sum -= erso_pkg::UNITS_PER_TENTH_KM_DEF;
			trip_count = trip_count + 1'b1;
			tenth_carries++;
		end
		trip_remainder = sum[erso_pkg::DIST_W-1:0];
		tick_count = tick_count + 1'b1;
		r.due = 1'b0;
		if (tick_count >= cfg.report_period) begin
			tick_count = '0;
			r.due = 1'b1;
			due_flags++;
		end
		r.rpm = present_rpm;
		r.speed = spd[erso_pkg::SPEED_W-1:0];
		r.trip = trip_count;
	endtask

	always @(posedge clk or negedge arst_n) begin
		reading_t predicted;
		reading_t want;
		if (!arst_n) begin
			cfg.rpm_per_count = erso_pkg::RST_RPM_PER_COUNT;
			cfg.max_position = erso_pkg::RST_MAX_POSITION;
			cfg.slew_step = erso_pkg::RST_SLEW_STEP;
			cfg.speed_max = erso_pkg::RST_SPEED_MAX;
			cfg.report_period = erso_pkg::RST_REPORT_PERIOD;
			last_count = '0;
			position = '0;
			goal_rpm = '0;
			present_rpm = '0;
			trip_remainder = '0;
			trip_count = '0;
			tick_count = '0;
			readings_in_flight.delete();
			fail_count = 0;
			readings_checked = 0;
			due_flags = 0;
			tenth_carries = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[erso_pkg::ADDR_W-1:2])
					erso_pkg::REG_RPM_PER_COUNT: cfg.rpm_per_count = pwdata[erso_pkg::RPC_W-1:0];
					erso_pkg::REG_MAX_POSITION:  cfg.max_position = pwdata[erso_pkg::POS_W-1:0];
					erso_pkg::REG_SLEW_STEP:     cfg.slew_step = pwdata[erso_pkg::RPM_W-1:0];
					erso_pkg::REG_SPEED_MAX:     cfg.speed_max = pwdata[erso_pkg::SPEED_W-1:0];
					erso_pkg::REG_REPORT_PERIOD: cfg.report_period = pwdata[erso_pkg::PERIOD_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				step_odometer(counter_value, predicted);
				readings_in_flight.push_back(predicted);
			end
			if (out_valid && out_ready) begin
				if (readings_in_flight.size() == 0) begin
					report_mismatch($sformatf("reading rpm %0d with no tick pending", rpm_out));
				end else begin
					want = readings_in_flight.pop_front();
					readings_checked++;
					if (rpm_out !== want.rpm)
						report_mismatch($sformatf("rpm_out %0d, want %0d", rpm_out, want.rpm));
					if (road_speed !== want.speed)
						report_mismatch($sformatf("road_speed %0d, want %0d",
							road_speed, want.speed));
					if (trip_tenths !== want.trip)
						report_mismatch($sformatf("trip_tenths %0d, want %0d",
							trip_tenths, want.trip));
					if (trip_due !== want.due)
						report_mismatch($sformatf("trip_due %0b, want %0b", trip_due, want.due));
				end
			end
		end
		outstanding = readings_in_flight.size();
	end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Encoder rpm slew odometer testbench
// Drives encoder tick requests and register settings into the block, with
// bursty input and a stalling receiver; a checker beside the block predicts
// every reading and the verdict comes from its failure count.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int PHASES          = 10;
	localparam int TICKS_PER_PHASE = 120;
	localparam int HOLD_CYCLES     = 60;
	localparam int TAIL_CYCLES     = 12;

	// addresses past the register list; writes there must change nothing
	localparam logic [2:0] REG_UNMAPPED_LO = 3'd5;
	localparam logic [2:0] REG_UNMAPPED_HI = 3'd7;

	logic                              clk;
	logic                              arst_n;
	logic                              psel;
	logic                              penable;
	logic                              pwrite;
	logic [erso_pkg::ADDR_W-1:0]       paddr;
	logic [erso_pkg::DATA_W-1:0]       pwdata;
	logic [erso_pkg::DATA_W-1:0]       prdata;
	logic                              pready;
	logic                              in_valid;
	logic                              in_ready;
	logic [erso_pkg::CNT_W-1:0]        counter_value;
	logic                              out_valid;
	logic                              out_ready;
	logic [erso_pkg::RPM_W-1:0]        rpm_out;
	logic [erso_pkg::SPEED_W-1:0]      road_speed;
	logic [erso_pkg::DIST_W-1:0]       trip_tenths;
	logic                              trip_due;

	int fail_count;
	int outstanding;
	int readings_checked;
	int due_flags;
	int tenth_carries;
	int ticks_sent = 0;
	int settings_applied = 0;
	int cycle_count = 0;

	// raised by the stimulus, cleared by the receiver once its hold-off ends
	bit hold_off = 1'b0;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	encoder_rpm_slew_odometer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.counter_value (counter_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.rpm_out       (rpm_out),
		.road_speed    (road_speed),
		.trip_tenths   (trip_tenths),
		.trip_due      (trip_due)
	);

	odometer_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.pready           (pready),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.counter_value    (counter_value),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.rpm_out          (rpm_out),
		.road_speed       (road_speed),
		.trip_tenths      (trip_tenths),
		.trip_due         (trip_due),
		.fail_count       (fail_count),
		.outstanding      (outstanding),
		.readings_checked (readings_checked),
		.due_flags        (due_flags),
		.tenth_carries    (tenth_carries)
	);

	// Write one register: setup cycle, then access cycle until pready.
	// Call right after a rising edge.
	task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
		paddr <= {index, 2'b00};
		pwdata <= value;
		pwrite <= 1'b1;
		psel <= 1'b1;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Offer one tick request and hold it until it is taken. in_ready only
	// moves on rising edges, so the falling edge shows what the next rising
	// edge will see.
	task automatic offer_tick(input logic [erso_pkg::CNT_W-1:0] reading);
		in_valid <= 1'b1;
		counter_value <= reading;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		ticks_sent++;
	endtask

	task automatic idle_cycles(input int count);
		in_valid <= 1'b0;
		repeat (count) @(posedge clk);
	endtask

	// Drop valid and wait until every predicted reading has come back.
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		@(posedge clk);
	endtask

	// Zero, one, the top of the field, or anything in between.
	function automatic logic [31:0] pick_level(input int unsigned top);
		int unsigned sel;
		sel = $urandom_range(0, 7);
		case (sel)
			0: return 32'd0;
			1: return 32'd1;
			2: return 32'(top);
			default: return 32'($urandom_range(1, top));
		endcase
	endfunction

	// Phase 0 zeroes every register, phase 1 sets every register to the top
	// of its field, later phases mix.
	task automatic apply_setting(input int phase);
		logic [31:0] slew;
		if (phase == 0) begin
			write_reg(erso_pkg::REG_RPM_PER_COUNT, 32'd0);
			write_reg(erso_pkg::REG_MAX_POSITION, 32'd0);
			write_reg(erso_pkg::REG_SLEW_STEP, 32'd0);
			write_reg(erso_pkg::REG_SPEED_MAX, 32'd0);
			write_reg(erso_pkg::REG_REPORT_PERIOD, 32'd0);
		end else if (phase == 1) begin
			write_reg(erso_pkg::REG_RPM_PER_COUNT, 32'd1023);
			write_reg(erso_pkg::REG_MAX_POSITION, 32'd1023);
			write_reg(erso_pkg::REG_SLEW_STEP, 32'd65535);
			write_reg(erso_pkg::REG_SPEED_MAX, 32'd1023);
			write_reg(erso_pkg::REG_REPORT_PERIOD, 32'd255);
		end else begin
			// favor slow slews so the rpm ramp stays visible over many ticks
			slew = $urandom_range(0, 1) ? pick_level(65535) : 32'($urandom_range(1, 400));
			write_reg(erso_pkg::REG_RPM_PER_COUNT, pick_level(1023));
			write_reg(erso_pkg::REG_MAX_POSITION, pick_level(1023));
			write_reg(erso_pkg::REG_SLEW_STEP, slew);
			write_reg(erso_pkg::REG_SPEED_MAX, pick_level(1023));
			write_reg(erso_pkg::REG_REPORT_PERIOD, pick_level(255));
		end
		settings_applied++;
	endtask

	// Move the encoder: mostly small steps in the current direction, some
	// standstills, wider swings, jumps at the edge of the signed range and
	// an occasional unrelated reading.
	function automatic logic [erso_pkg::CNT_W-1:0] next_count(
		input logic [erso_pkg::CNT_W-1:0] now, input bit climbing);
		int unsigned pick;
		int signed   step;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			step = 0;
		else if (pick < 75)
			step = climbing ? int'($urandom_range(0, 30)) - 6 : 6 - int'($urandom_range(0, 30));
		else if (pick < 90)
			step = int'($urandom_range(0, 400)) - 200;
		else if (pick < 96)
			return 16'($urandom);
		else
			step = climbing ? 32767 : -32768;
		return now + step[15:0];
	endfunction

	// Receiver: stretches of its own style, always ready, coin flip, mostly
	// ready or a rotating stall pattern. A hold-off request from the stimulus
	// wins and keeps out_ready low until the receiver clears hold_off.
	initial begin
		int       stretch;
		int       style;
		logic [7:0] stall_pattern;
		stall_pattern = 8'b1011_0110;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			style = $urandom_range(0, 3);
			stretch = $urandom_range(1, 48);
			while (stretch > 0) begin
				@(posedge clk);
				stretch--;
				if (hold_off) begin
					out_ready <= 1'b0;
					repeat (HOLD_CYCLES - 1) @(posedge clk);
					hold_off = 1'b0;
				end else begin
					case (style)
						0: out_ready <= 1'b1;
						1: out_ready <= 1'($urandom_range(0, 1));
						2: out_ready <= ($urandom_range(0, 5) != 0);
						default: begin
							out_ready <= stall_pattern[0];
							stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
						end
					endcase
				end
			end
		end
	end

	// Watchdog: end the run if the block stops making progress.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d readings outstanding", cycle_count, outstanding);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int                          phase;
		int                          n;
		int                          burst_left;
		bit                          climbing;
		bit                          gapless;
		logic [erso_pkg::CNT_W-1:0]  reading;

		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		counter_value <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, reset settings first: standstill on the very first
		// tick, small and large moves, clamp at the top, a backward jump
		// across the counter wrap, a forward move across the wrap, and both
		// ends of the signed difference range.
		offer_tick(16'h0000);
		offer_tick(16'h0001);
		offer_tick(16'h0001);
		offer_tick(16'h003D);
		offer_tick(16'h012C);
		offer_tick(16'hFFFF);
		offer_tick(16'h0004);
		offer_tick(16'h8004);
		offer_tick(16'h0003);

		// Every register but the report period at the top of its field; the product
		// saturates and a one-tick period flags every tick. Unmapped addresses change nothing.
		drain();
		write_reg(erso_pkg::REG_RPM_PER_COUNT, 32'd1023);
		write_reg(erso_pkg::REG_MAX_POSITION, 32'd1023);
		write_reg(erso_pkg::REG_SLEW_STEP, 32'd65535);
		write_reg(erso_pkg::REG_SPEED_MAX, 32'd1023);
		write_reg(erso_pkg::REG_REPORT_PERIOD, 32'd1);
		write_reg(REG_UNMAPPED_LO, 32'hFFFF_FFFF);
		write_reg(REG_UNMAPPED_HI, 32'h0000_0000);
		settings_applied++;
		offer_tick(16'h0402);
		offer_tick(16'h0402);

		// Lower the position clamp under the held position, freeze the slew:
		// the still tick keeps position, the next move clamps it.
		drain();
		write_reg(erso_pkg::REG_MAX_POSITION, 32'd10);
		write_reg(erso_pkg::REG_SLEW_STEP, 32'd0);
		write_reg(erso_pkg::REG_REPORT_PERIOD, 32'd20);
		settings_applied++;
		offer_tick(16'h0402);
		offer_tick(16'h0403);
		offer_tick(16'h0410);
		offer_tick(16'h0400);
		offer_tick(16'h0401);

		// Zero rpm per count drops the target; the period falls under the
		// tick count, so the next tick flags.
		drain();
		write_reg(erso_pkg::REG_RPM_PER_COUNT, 32'd0);
		write_reg(erso_pkg::REG_SLEW_STEP, 32'd1000);
		write_reg(erso_pkg::REG_REPORT_PERIOD, 32'd3);
		settings_applied++;
		offer_tick(16'h0405);
		offer_tick(16'h0405);
		offer_tick(16'h0406);

		// Zero period flags every tick; zero speed clamp.
		drain();
		write_reg(erso_pkg::REG_RPM_PER_COUNT, 32'd1);
		write_reg(erso_pkg::REG_SLEW_STEP, 32'd1);
		write_reg(erso_pkg::REG_SPEED_MAX, 32'd0);
		write_reg(erso_pkg::REG_REPORT_PERIOD, 32'd0);
		settings_applied++;
		offer_tick(16'h0407);
		offer_tick(16'h0300);
		offer_tick(16'h0300);
		reading = 16'h0300;

		// Random part: one register setting per phase, encoder walks with
		// drifting direction, sender in bursts or back to back.
		for (phase = 0; phase < PHASES; phase++) begin
			drain();
			apply_setting(phase);
			climbing = 1'b1;
			gapless = (phase % 4 == 2);
			burst_left = $urandom_range(1, 30);
			for (n = 0; n < TICKS_PER_PHASE; n++) begin
				if ($urandom_range(0, 39) == 0)
					climbing = !climbing;
				// starve the receiver and keep requests coming until the
				// pipeline backs up into in_ready
				if (phase == 3 && n == 40) begin
					hold_off = 1'b1;
					burst_left = 30;
				end
				// pause the sender until every reading is back
				if (phase == 6 && n == 60)
					drain();
				reading = next_count(reading, climbing);
				offer_tick(reading);
				if (!gapless) begin
					if (burst_left == 0) begin
						idle_cycles($urandom_range(1, 12));
						burst_left = $urandom_range(1, 30);
					end else begin
						burst_left--;
					end
				end
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d ticks over %0d register settings, field extremes and unmapped writes.",
			ticks_sent, settings_applied);
		$display("Checked %0d readings: %0d report flags, %0d tenth-km carries, %0d mismatches.",
			readings_checked, due_flags, tenth_carries, fail_count);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== encoder_rpm_slew_odometer.f =====
+incdir+hdl
hdl/erso_pkg.sv
hdl/encoder_rpm_slew_odometer.sv
bench/odometer_checker.sv
bench/tb.sv
